FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the shaper RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define TBS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/tbs_pkg.sv
// Shared types, codes and sizes for the token bucket packet shaper.
// No dependencies; imported by every shaper module.
`default_nettype none

package tbs_pkg;

	localparam int QDEPTH = 64;
	localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W  = $clog2(QDEPTH + 1);
	localparam int ID_W   = 16;
	localparam int TOK_W  = 10;
	localparam int DROP_W = 16;

	typedef enum logic {
		CMD_PACKET = 1'b0,
		CMD_TICK   = 1'b1
	} cmd_t;

	typedef enum logic {
		CFG_BUCKET_DEPTH      = 1'b0,
		CFG_TOKENS_PER_PACKET = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_QUEUED  = 2'd1,
		ST_TOO_BIG = 2'd2,
		ST_FULL    = 2'd3
	} pkt_status_t;

	typedef struct packed {
		logic [TOK_W-1:0]  tokens;
		logic [PTR_W-1:0]  rd_ptr;
		logic [PTR_W-1:0]  wr_ptr;
		logic [CNT_W-1:0]  occ;
		logic [DROP_W-1:0] pkt_drops;
		logic [DROP_W-1:0] tok_drops;
	} state_t;

	typedef struct packed {
		logic              released;
		logic [ID_W-1:0]   released_id;
		pkt_status_t       status;
		logic              token_dropped;
	} result_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [DROP_W-1:0] sat_inc(input logic [DROP_W-1:0] v);
		return (v == '1) ? v : v + DROP_W'(1);
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tbs_queue.sv
// Packet id storage: one write port, one registered read port with write bypass.
// Depends on tbs_pkg.
`default_nettype none

module tbs_queue
	import tbs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [PTR_W-1:0] wr_addr,
	input  wire logic [ID_W-1:0]  wr_data,
	input  wire logic [PTR_W-1:0] rd_addr,
	output logic      [ID_W-1:0]  head_id
);

	logic [ID_W-1:0] mem [QDEPTH];
	logic [ID_W-1:0] rd_data_q;
	logic [ID_W-1:0] byp_data_q;
	logic            byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q  <= mem[rd_addr];
		byp_data_q <= wr_data;
	end

	// Forward a write that lands on the address being read this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign head_id = byp_q ? byp_data_q : rd_data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tbs_step.sv
// Next-state and result logic for one shaper item.
// Depends on tbs_pkg.
`default_nettype none

module tbs_step
	import tbs_pkg::*;
(
	input  wire cmd_t             cmd,
	input  wire logic [ID_W-1:0]  id,
	input  wire logic [TOK_W-1:0] depth,
	input  wire logic [TOK_W-1:0] cost,
	input  wire state_t           cur,
	input  wire logic [ID_W-1:0]  head_id,
	output state_t                nxt,
	output result_t               res,
	output logic                  push
);

	logic [TOK_W-1:0] tokens_add;
	logic [CNT_W-1:0] occ_add;
	logic             room;
	logic             pkt_drop;
	logic             release_now;

	always_comb begin
		nxt         = cur;
		res         = '0;
		res.status  = ST_NONE;
		push        = 1'b0;
		pkt_drop    = 1'b0;
		room        = cur.tokens < depth;
		tokens_add  = cur.tokens;

		unique case (cmd)
			CMD_PACKET: begin
				priority if (cost > depth) begin
					res.status = ST_TOO_BIG;
					pkt_drop   = 1'b1;
				end else if (cur.occ == CNT_W'(QDEPTH)) begin
					res.status = ST_FULL;
					pkt_drop   = 1'b1;
				end else begin
					res.status = ST_QUEUED;
					push       = 1'b1;
				end
			end
			CMD_TICK: begin
				if (room) begin
					tokens_add = cur.tokens + TOK_W'(1);
				end else begin
					res.token_dropped = 1'b1;
					nxt.tok_drops     = sat_inc(cur.tok_drops);
				end
			end
			default: ;
		endcase

		if (pkt_drop) begin
			nxt.pkt_drops = sat_inc(cur.pkt_drops);
		end
		if (push) begin
			nxt.wr_ptr = ptr_inc(cur.wr_ptr);
		end
		occ_add     = cur.occ + CNT_W'(push);
		release_now = (occ_add != '0) && (tokens_add >= cost);

		// An empty queue can only release the packet that arrived this item.
		if (release_now) begin
			res.released    = 1'b1;
			res.released_id = (cur.occ == '0) ? id : head_id;
			nxt.rd_ptr      = ptr_inc(cur.rd_ptr);
			nxt.occ         = occ_add - CNT_W'(1);
			nxt.tokens      = tokens_add - cost;
		end else begin
			nxt.occ    = occ_add;
			nxt.tokens = tokens_add;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/token_bucket_packet_shaper_top.sv
// Top level of the token bucket packet shaper: input register, step logic, result register.
// Depends on tbs_pkg, tbs_queue, tbs_step and assert_macros.svh.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | sink      | in_valid/in_stall  | command, packet_id
//   out     | source    | out_valid/out_stall| released, released_id, packet_status,
//           |           |                    | token_dropped, token_level, queue_count,
//           |           |                    | packets_dropped_total, tokens_dropped_total
//   cfg     | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each transaction passes through the input register, then through the step logic into the
// result register. A new transaction can enter every cycle while the output is not stalled.
// The id queue read is registered; the address for the next head is issued as each item
// retires, and a write to that same address is forwarded.
// Reset clears the bucket, queue pointers, counts and drop totals; config returns to
// depth 10, cost 3. A stalled output holds the result and backs up into in_stall.
`default_nettype none

`include "assert_macros.svh"

module token_bucket_packet_shaper_top
	import tbs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              command,
	input  wire logic [ID_W-1:0]   packet_id,

	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   released,
	output logic      [ID_W-1:0]   released_id,
	output logic      [1:0]        packet_status,
	output logic                   token_dropped,
	output logic      [TOK_W-1:0]  token_level,
	output logic      [CNT_W-1:0]  queue_count,
	output logic      [DROP_W-1:0] packets_dropped_total,
	output logic      [DROP_W-1:0] tokens_dropped_total,

	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [TOK_W-1:0]  cfg_data
);

	// Configuration registers
	logic [TOK_W-1:0] depth_q;
	logic [TOK_W-1:0] cost_q;

	// Input register
	logic             valid_s1;
	cmd_t             cmd_s1;
	logic [ID_W-1:0]  id_s1;

	// Architectural state
	state_t           st_q;

	// Step outputs
	state_t           nxt;
	result_t          res;
	logic             push;
	logic [ID_W-1:0]  head_id;
	logic [PTR_W-1:0] rd_addr;

	// Result register
	result_t          res_q;
	logic [TOK_W-1:0] level_q;
	logic [CNT_W-1:0] count_q;

	logic             res_free;
	logic             fire;

	assign cfg_ready = 1'b1;

	// Retire the held item when the result register can take it.
	assign res_free = !out_valid || !out_stall;
	assign fire     = valid_s1 && res_free;
	assign in_stall = valid_s1 && !res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= TOK_W'(10);
			cost_q  <= TOK_W'(3);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BUCKET_DEPTH:      depth_q <= cfg_data;
				CFG_TOKENS_PER_PACKET: cost_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Load the input register whenever it is empty or draining this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1 <= cmd_t'(command);
			id_s1  <= packet_id;
		end
	end

	// Advance bucket and queue state as each item retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= nxt;
		end
	end

	// Point the read port at the head the next item will see.
	assign rd_addr = fire ? nxt.rd_ptr : st_q.rd_ptr;

	tbs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fire && push),
		.wr_addr (st_q.wr_ptr),
		.wr_data (id_s1),
		.rd_addr (rd_addr),
		.head_id (head_id)
	);

	tbs_step u_step (
		.cmd     (cmd_s1),
		.id      (id_s1),
		.depth   (depth_q),
		.cost    (cost_q),
		.cur     (st_q),
		.head_id (head_id),
		.nxt     (nxt),
		.res     (res),
		.push    (push)
	);

	// Hold the result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_free) begin
			out_valid <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q   <= res;
			level_q <= nxt.tokens;
			count_q <= nxt.occ;
		end
	end

	assign released              = res_q.released;
	assign released_id           = res_q.released_id;
	assign packet_status         = res_q.status;
	assign token_dropped         = res_q.token_dropped;
	assign token_level           = level_q;
	assign queue_count           = count_q;
	assign packets_dropped_total = st_q.pkt_drops;
	assign tokens_dropped_total  = st_q.tok_drops;

	`TBS_ASSERT(a_occ_bound, st_q.occ <= CNT_W'(QDEPTH), "queue occupancy beyond depth")
	`TBS_ASSERT(a_empty_ptrs, (st_q.occ == '0) |-> (st_q.rd_ptr == st_q.wr_ptr),
		"empty queue with unequal pointers")
	`TBS_ASSERT(a_fire_result, fire |=> out_valid, "retired item left no result")
	`TBS_ASSERT_NEVER(a_release_zero, res_q.released == 1'b0 && res_q.released_id != '0
		&& out_valid, "id shown without release")

endmodule

`default_nettype wire

FILE: test/token_bucket_packet_shaper_top_tb.sv
// Self-checking testbench for token_bucket_packet_shaper_top: bucket, id queue and drop totals.
// Depends on tbs_pkg and the shaper RTL; the bucket and queue are predicted in place.
// Directed cases, a queue fill, random config phases and a zero-depth drop run go in turn.
module token_bucket_packet_shaper_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tbs_pkg::*;

	localparam realtime CLK_PERIOD   = 4.0;
	localparam int      RESET_CYCLES = 11;
	// Extra settling after the last result before touching config.
	localparam int      SETTLE       = 4;
	localparam realtime RUN_LIMIT    = 4ms;
	localparam int      PHASES       = 7;
	localparam int      PHASE_ITEMS  = 50;
	localparam int      DROP_PAIRS   = 20;

	// One expected result transaction, field for field as it leaves the block.
	typedef struct packed {
		logic              released;
		logic [ID_W-1:0]   released_id;
		pkt_status_t       status;
		logic              token_dropped;
		logic [TOK_W-1:0]  level;
		logic [CNT_W-1:0]  count;
		logic [DROP_W-1:0] pkt_total;
		logic [DROP_W-1:0] tok_total;
	} shaper_out_t;

	typedef enum int {
		RX_OPEN,
		RX_RANDOM,
		RX_HOLD
	} rx_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              command = 1'b0;
	logic [ID_W-1:0]   packet_id = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              released;
	logic [ID_W-1:0]   released_id;
	logic [1:0]        packet_status;
	logic              token_dropped;
	logic [TOK_W-1:0]  token_level;
	logic [CNT_W-1:0]  queue_count;
	logic [DROP_W-1:0] packets_dropped_total;
	logic [DROP_W-1:0] tokens_dropped_total;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = 1'b0;
	logic [TOK_W-1:0]  cfg_data = '0;

	// Predicted shaper state and config, mirrored from reset values.
	logic [TOK_W-1:0]  depth_cfg = TOK_W'(10);
	logic [TOK_W-1:0]  cost_cfg = TOK_W'(3);
	logic [TOK_W-1:0]  bucket_level = '0;
	logic [ID_W-1:0]   held_ids[$];
	logic [DROP_W-1:0] pkt_drop_total = '0;
	logic [DROP_W-1:0] tok_drop_total = '0;

	shaper_out_t       results_due[$];

	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int releases_seen = 0;
	int too_big_seen = 0;
	int full_seen = 0;
	int tok_drops_seen = 0;
	int reg_writes = 0;

	// Sender pacing and receiver stall shaping.
	int       burst_left = 0;
	bit       sender_fast = 1'b0;
	bit       rx_quiet = 1'b0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_cycle = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	token_bucket_packet_shaper_top i_dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.in_valid              (in_valid),
		.in_stall              (in_stall),
		.command               (command),
		.packet_id             (packet_id),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.released              (released),
		.released_id           (released_id),
		.packet_status         (packet_status),
		.token_dropped         (token_dropped),
		.token_level           (token_level),
		.queue_count           (queue_count),
		.packets_dropped_total (packets_dropped_total),
		.tokens_dropped_total  (tokens_dropped_total),
		.cfg_valid             (cfg_valid),
		.cfg_ready             (cfg_ready),
		.cfg_index             (cfg_index),
		.cfg_data              (cfg_data)
	);

	// Advance the predicted bucket and queue by one accepted item and return its result.
	function automatic shaper_out_t shape_item(cmd_t cmd, logic [ID_W-1:0] id);
		shaper_out_t r;
		r = '0;
		r.status = ST_NONE;
		if (cmd == CMD_PACKET) begin
			// Size check comes first: a packet that can never be paid for never queues.
			if (cost_cfg > depth_cfg) begin
				r.status = ST_TOO_BIG;
				if (pkt_drop_total != '1) pkt_drop_total++;
			end else if (held_ids.size() >= QDEPTH) begin
				r.status = ST_FULL;
				if (pkt_drop_total != '1) pkt_drop_total++;
			end else begin
				r.status = ST_QUEUED;
				held_ids.push_back(id);
			end
		end else if (bucket_level < depth_cfg) begin
			bucket_level++;
		end else begin
			// Bucket at or above depth (depth may have been lowered under the level).
			r.token_dropped = 1'b1;
			if (tok_drop_total != '1) tok_drop_total++;
		end
		// At most one release per item, always against the current cost.
		if (held_ids.size() != 0 && bucket_level >= cost_cfg) begin
			bucket_level -= cost_cfg;
			r.released = 1'b1;
			r.released_id = held_ids.pop_front();
		end
		r.level = bucket_level;
		r.count = CNT_W'(held_ids.size());
		r.pkt_total = pkt_drop_total;
		r.tok_total = tok_drop_total;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Compare every result transaction against the oldest expectation.
	always @(posedge clk) begin
		shaper_out_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			results_seen++;
			if (results_due.size() == 0) begin
				$error("result transaction with no item outstanding");
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("released", want.released, released);
				check_field("released_id", want.released_id, released_id);
				check_field("packet_status", want.status, packet_status);
				check_field("token_dropped", want.token_dropped, token_dropped);
				check_field("token_level", want.level, token_level);
				check_field("queue_count", want.count, queue_count);
				check_field("packets_dropped_total", want.pkt_total, packets_dropped_total);
				check_field("tokens_dropped_total", want.tok_total, tokens_dropped_total);
				releases_seen += want.released;
				too_big_seen += (want.status == ST_TOO_BIG);
				full_seen += (want.status == ST_FULL);
				tok_drops_seen += want.token_dropped;
			end
		end
	end

	// Receiver: switch between open, random and long-hold stall patterns every so often.
	// In quiet mode stall only one cycle in eight, so the drop run streams nearly unbroken.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(16, 160);
		end
		rx_left--;
		rx_cycle++;
		if (rx_quiet)
			out_stall <= (rx_cycle % 8 == 0);
		else case (rx_mode)
			RX_OPEN:   out_stall <= 1'b0;
			RX_RANDOM: out_stall <= ($urandom_range(0, 99) < 40);
			default:   out_stall <= (rx_cycle % 11 < 7);
		endcase
	end

	// Drop valid and hold off the sender; n sets the length of the gap (n >= 1).
	task automatic idle_sender(int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Present one item, hold it until accepted, then record what it should produce.
	task automatic send_item(cmd_t cmd, logic [ID_W-1:0] id);
		@(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		packet_id <= id;
		do @(posedge clk); while (in_stall !== 1'b0);
		results_due.push_back(shape_item(cmd, id));
		items_sent++;
		if (!sender_fast) begin
			if (burst_left > 0) burst_left--;
			if (burst_left == 0) begin
				idle_sender(($urandom_range(0, 3) == 0) ? $urandom_range(8, 20)
				                                        : $urandom_range(1, 4));
				// Now and then run a long burst with no gaps at all.
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				                                         : $urandom_range(1, 24);
			end
		end
	endtask

	// Hold off the sender until every outstanding result has come back, then settle.
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write one config register; only done with the block idle.
	task automatic set_reg(cfg_idx_t idx, logic [TOK_W-1:0] val);
		wait_for_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == CFG_BUCKET_DEPTH)
			depth_cfg = val;
		else
			cost_cfg = val;
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_shape(logic [TOK_W-1:0] depth, logic [TOK_W-1:0] cost);
		set_reg(CFG_BUCKET_DEPTH, depth);
		set_reg(CFG_TOKENS_PER_PACKET, cost);
	endtask

	// Reset config (depth 10, cost 3): queue, tick until paid, release; extreme ids.
	task automatic test_reset_defaults();
		send_item(CMD_PACKET, 16'h0000);
		repeat (3) send_item(CMD_TICK, 16'hFFFF);
		send_item(CMD_PACKET, 16'hFFFF);
		repeat (3) send_item(CMD_TICK, 16'h0000);
	endtask

	// Cost above depth: every arrival is dropped before the queue is looked at.
	task automatic test_too_big();
		set_shape(10'd4, 10'd5);
		send_item(CMD_PACKET, 16'hA5A5);
		send_item(CMD_TICK, 16'h0000);
		send_item(CMD_PACKET, 16'h5A5A);
	endtask

	// Fill the bucket, lower the depth under the level: ticks drop while the level is kept.
	task automatic test_depth_lowered();
		set_shape(10'd8, 10'd8);
		while (bucket_level < depth_cfg) send_item(CMD_TICK, 16'h1234);
		set_reg(CFG_BUCKET_DEPTH, 10'd2);
		send_item(CMD_TICK, 16'h0000);
		set_reg(CFG_TOKENS_PER_PACKET, 10'd1);
		send_item(CMD_PACKET, 16'hBEEF);
		send_item(CMD_TICK, 16'h0000);
	endtask

	// Unreachable cost parks packets until the queue overflows; zero cost then drains
	// one per item, wrapping both queue pointers.
	task automatic test_queue_full();
		set_shape(10'd1023, 10'd1023);
		repeat (QDEPTH + 2) send_item(CMD_PACKET, ID_W'($urandom_range(0, 65535)));
		set_reg(CFG_TOKENS_PER_PACKET, 10'd0);
		repeat (QDEPTH + 6)
			send_item(($urandom_range(0, 1) != 0) ? CMD_TICK : CMD_PACKET,
			          ID_W'($urandom_range(0, 65535)));
	endtask

	// Random phases, each under a fresh config; mostly payable costs so releases keep coming.
	task automatic test_random_phases();
		logic [TOK_W-1:0] depth;
		logic [TOK_W-1:0] cost;
		int               tick_pct;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       begin depth = 10'd1023; cost = 10'd1;    end
				1:       begin depth = 10'd0;    cost = 10'd0;    end
				2:       begin depth = 10'd1;    cost = 10'd1023; end
				default: begin
					depth = ($urandom_range(0, 5) == 0) ? 10'd1023
					                                    : TOK_W'($urandom_range(0, 40));
					if ($urandom_range(0, 99) < 85 || depth == 10'd1023)
						cost = TOK_W'($urandom_range(0, (depth < 6) ? depth : 6));
					else
						cost = TOK_W'($urandom_range(depth + 1, 1023));
				end
			endcase
			set_shape(depth, cost);
			tick_pct = $urandom_range(30, 75);
			repeat (PHASE_ITEMS)
				send_item(($urandom_range(0, 99) < tick_pct) ? CMD_TICK : CMD_PACKET,
				          ID_W'($urandom_range(0, 65535)));
		end
	endtask

	// Zero depth with nonzero cost: every packet and every tick is a drop, sent back to back.
	task automatic test_zero_depth_drops();
		set_shape(10'd0, 10'd1);
		sender_fast = 1'b1;
		rx_quiet = 1'b1;
		repeat (DROP_PAIRS) begin
			send_item(CMD_PACKET, ID_W'($urandom_range(0, 65535)));
			send_item(CMD_TICK, ID_W'($urandom_range(0, 65535)));
		end
		sender_fast = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		// Hold reset for a fixed count, release it away from the rising edge.
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_too_big();
		test_depth_lowered();
		test_queue_full();
		// Pause the sender mid-run until the block has fully caught up.
		wait_for_results();
		test_random_phases();
		test_zero_depth_drops();

		wait_for_results();
		repeat (2 * SETTLE) @(posedge clk);

		$display("Sent %0d items, checked %0d results: %0d releases, %0d too-big drops,",
		         items_sent, results_seen, releases_seen, too_big_seen);
		$display("%0d queue-full drops, %0d token drops, %0d register writes.",
		         full_seen, tok_drops_seen, reg_writes);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog: a stuck handshake ends the run here.
	initial begin
		#(RUN_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
